// ===== src/wswt_pkg.sv =====
package wswt_pkg;

	localparam int WSWT_TABLE_ENTRIES = 64;

	localparam int ID_W   = 16;
	localparam int TIME_W = 32;
	localparam int DUR_W  = 24;
	// four durations summed
	localparam int DSUM_W = DUR_W + 2;

	// request token handed from cell to cell
	typedef struct packed {
		logic [ID_W-1:0]   fid;
		logic [TIME_W-1:0] sub;
		logic [TIME_W-1:0] win_open;
		logic [TIME_W-1:0] win_close;
		logic              done;
		logic              hot;
	} wswt_tok_t;

endpackage

// ===== src/wswt_cell.sv =====
module wswt_cell
	import wswt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_vld,
	input  wswt_tok_t in_tok,
	output logic      out_vld,
	output wswt_tok_t out_tok
);

	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] open_q;
	logic [TIME_W-1:0] close_q;
	logic              out_vld_q;
	wswt_tok_t         out_tok_q;

	logic      live;
	logic      match;
	logic      alloc;
	logic      hot_w;
	wswt_tok_t tok_nxt;

	always_comb begin
		live    = in_vld && !in_tok.done;
		match   = live && valid_q && (id_q == in_tok.fid);
		alloc   = live && !valid_q;
		hot_w   = (open_q <= in_tok.sub) && (close_q >= in_tok.sub);
		tok_nxt = in_tok;
		if (match) begin
			tok_nxt.done = 1'b1;
			tok_nxt.hot  = hot_w;
		end else if (alloc) begin
			tok_nxt.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= in_vld;
			if (alloc) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			out_tok_q <= tok_nxt;
		end
		if (alloc) begin
			id_q    <= in_tok.fid;
			open_q  <= in_tok.win_open;
			close_q <= in_tok.win_close;
		end else if (match) begin
			if (in_tok.win_open < open_q) begin
				open_q <= in_tok.win_open;
			end
			if (in_tok.win_close > close_q) begin
				close_q <= in_tok.win_close;
			end
		end
	end

	assign out_vld = out_vld_q;
	assign out_tok = out_tok_q;

endmodule

// ===== src/warm_start_window_table_core.sv =====
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+--------------------------------------------
// in      | in        | in_valid / in_stall   | function_id, submit_time, build_duration,
//         |           |                       | cold_start_duration, hot_start_duration,
//         |           |                       | run_duration
// out     | out       | out_valid / out_stall | was_hot, start_latency, build_charged,
//         |           |                       | run_charged, table_full
// cfg     | in        | cfg_valid / cfg_ready | cfg_data (keep_alive_window)
//
// from its beat to the result beat being offered, a request passes ST_SUM, ST_CLOSE, ST_LAUNCH and
// ST_WAIT, its token walking the row of TABLE_ENTRIES cells one cell per cycle
// the next request beat is taken the cycle after the result is registered, so only one token
// is ever in the row
// arst_n clears the fsm, the output valid, keep_alive_window and every cell's valid bit
// a stalled result holds the output register; the next request can still be taken, and its
// token waits at the head of the row until the output register is free
module warm_start_window_table_core
	import wswt_pkg::*;
#(
	parameter int TABLE_ENTRIES = WSWT_TABLE_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ID_W-1:0]   function_id,
	input  logic [TIME_W-1:0] submit_time,
	input  logic [DUR_W-1:0]  build_duration,
	input  logic [DUR_W-1:0]  cold_start_duration,
	input  logic [DUR_W-1:0]  hot_start_duration,
	input  logic [DUR_W-1:0]  run_duration,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              was_hot,
	output logic [DUR_W-1:0]  start_latency,
	output logic [DUR_W-1:0]  build_charged,
	output logic [DUR_W-1:0]  run_charged,
	output logic              table_full,
	// keep-alive window register
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DUR_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CLOSE,
		ST_LAUNCH,
		ST_WAIT
	} state_t;

	state_t st_q;
	logic   out_valid_q;

	// keep-alive register
	logic [DUR_W-1:0] keep_alive_q;

	// captured request beat
	logic [ID_W-1:0]   fid_q;
	logic [TIME_W-1:0] sub_q;
	logic [DUR_W-1:0]  bld_q;
	logic [DUR_W-1:0]  cold_q;
	logic [DUR_W-1:0]  hot_q;
	logic [DUR_W-1:0]  run_q;

	// window candidates
	logic [DSUM_W-1:0] dsum_q;
	logic [TIME_W-1:0] open_c_q;
	logic [TIME_W-1:0] close_c_q;
	logic [TIME_W:0]   open_sum;
	logic [TIME_W:0]   close_sum;

	// result register
	logic             was_hot_q;
	logic [DUR_W-1:0] start_latency_q;
	logic [DUR_W-1:0] build_charged_q;
	logic [DUR_W-1:0] run_charged_q;
	logic             table_full_q;

	// the row of cells
	logic      chain_vld [TABLE_ENTRIES+1];
	wswt_tok_t chain_tok [TABLE_ENTRIES+1];
	logic      inject;
	logic      end_vld;
	wswt_tok_t end_tok;
	logic      in_acc;

	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// token enters the row only when the output register is free
	assign inject  = (st_q == ST_LAUNCH) && !out_valid_q;
	assign end_vld = chain_vld[TABLE_ENTRIES];
	assign end_tok = chain_tok[TABLE_ENTRIES];

	// saturating window sums, open is submit plus build, close adds cold start, run and keep-alive too
	assign open_sum  = {1'b0, sub_q} + {{(TIME_W+1-DUR_W){1'b0}}, bld_q};
	assign close_sum = {1'b0, sub_q} + {{(TIME_W+1-DSUM_W){1'b0}}, dsum_q};

	always_comb begin
		chain_vld[0]           = inject;
		chain_tok[0].fid       = fid_q;
		chain_tok[0].sub       = sub_q;
		chain_tok[0].win_open  = open_c_q;
		chain_tok[0].win_close = close_c_q;
		chain_tok[0].done      = 1'b0;
		chain_tok[0].hot       = 1'b0;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		wswt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (chain_vld[i]),
			.in_tok  (chain_tok[i]),
			.out_vld (chain_vld[i+1]),
			.out_tok (chain_tok[i+1])
		);
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_SUM;
					end
				end
				ST_SUM:   st_q <= ST_CLOSE;
				ST_CLOSE: st_q <= ST_LAUNCH;
				ST_LAUNCH: begin
					if (!out_valid_q) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// token leaves the last cell, result goes to the output register
					if (end_vld) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_alive_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			keep_alive_q <= cfg_data;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fid_q  <= function_id;
			sub_q  <= submit_time;
			bld_q  <= build_duration;
			cold_q <= cold_start_duration;
			hot_q  <= hot_start_duration;
			run_q  <= run_duration;
		end
		if (st_q == ST_SUM) begin
			dsum_q <= {2'b00, bld_q} + {2'b00, cold_q} + {2'b00, run_q}
				+ {2'b00, keep_alive_q};
			open_c_q <= open_sum[TIME_W] ? '1 : open_sum[TIME_W-1:0];
		end
		if (st_q == ST_CLOSE) begin
			close_c_q <= close_sum[TIME_W] ? '1 : close_sum[TIME_W-1:0];
		end
		if ((st_q == ST_WAIT) && end_vld) begin
			was_hot_q       <= end_tok.hot;
			start_latency_q <= end_tok.hot ? hot_q : cold_q;
			build_charged_q <= end_tok.hot ? '0 : bld_q;
			run_charged_q   <= run_q;
			// nothing matched and no free cell took the id
			table_full_q    <= !end_tok.done;
		end
	end

	assign out_valid     = out_valid_q;
	assign was_hot       = was_hot_q;
	assign start_latency = start_latency_q;
	assign build_charged = build_charged_q;
	assign run_charged   = run_charged_q;
	assign table_full    = table_full_q;

`ifndef SYNTHESIS
	// a token never enters the row while a result is still held
	a_inject_free: assert property (@(posedge clk) disable iff (!arst_n)
		inject |-> !out_valid_q)
		else $error("token injected while output register full");

	// a token only leaves the row while the sequencer waits for it
	a_end_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		end_vld |-> (st_q == ST_WAIT))
		else $error("token left the row outside the wait state");

	// the token arriving at the end always produces a result beat
	a_end_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		end_vld |=> out_valid)
		else $error("result not registered after token left the row");

	// a hot start implies the request found its entry
	a_hot_done: assert property (@(posedge clk) disable iff (!arst_n)
		(end_vld && end_tok.hot) |-> end_tok.done)
		else $error("hot start without a matching entry");
`endif

endmodule

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wswt_pkg::*;

	localparam int ENTRIES      = WSWT_TABLE_ENTRIES;
	// one request walks the whole row of cells, plus a little margin
	localparam int DRAIN_CYCLES = ENTRIES + 12;
	localparam int CYCLE_LIMIT  = 700000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;

	// one job request as offered on the request channel
	typedef struct packed {
		bit [ID_W-1:0]   fid;
		bit [TIME_W-1:0] sub;
		bit [DUR_W-1:0]  bld;
		bit [DUR_W-1:0]  cold;
		bit [DUR_W-1:0]  hot;
		bit [DUR_W-1:0]  run;
	} job_t;

	// what the block charges for one job
	typedef struct packed {
		logic             hot;
		logic [DUR_W-1:0] latency;
		logic [DUR_W-1:0] build;
		logic [DUR_W-1:0] run;
		logic             full;
	} charge_t;

	logic              clk                 = 1'b0;
	logic              arst_n              = 1'b0;
	logic              in_valid            = 1'b0;
	logic              in_stall;
	logic [ID_W-1:0]   function_id         = '0;
	logic [TIME_W-1:0] submit_time         = '0;
	logic [DUR_W-1:0]  build_duration      = '0;
	logic [DUR_W-1:0]  cold_start_duration = '0;
	logic [DUR_W-1:0]  hot_start_duration  = '0;
	logic [DUR_W-1:0]  run_duration        = '0;
	logic              out_valid;
	logic              out_stall           = 1'b0;
	logic              was_hot;
	logic [DUR_W-1:0]  start_latency;
	logic [DUR_W-1:0]  build_charged;
	logic [DUR_W-1:0]  run_charged;
	logic              table_full;
	logic              cfg_valid           = 1'b0;
	logic              cfg_ready;
	logic [DUR_W-1:0]  cfg_data            = '0;

	// shadow of the warm window table and the keep-alive register
	bit                tbl_valid [ENTRIES];
	bit [ID_W-1:0]     tbl_fid   [ENTRIES];
	bit [TIME_W-1:0]   tbl_open  [ENTRIES];
	bit [TIME_W-1:0]   tbl_close [ENTRIES];
	int                tbl_used   = 0;
	bit [DUR_W-1:0]    keep_alive = '0;

	// charges still owed by the block, oldest first
	charge_t           pending_charges[$];

	int                errors      = 0;
	int                cycles      = 0;
	bit                no_idle     = 1'b0;
	int                holds_asked = 0;
	int                holds_taken = 0;
	int                hold_left   = 0;
	int                burst_left  = 0;

	warm_start_window_table_core #(
		.TABLE_ENTRIES(ENTRIES)
	) uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.function_id        (function_id),
		.submit_time        (submit_time),
		.build_duration     (build_duration),
		.cold_start_duration(cold_start_duration),
		.hot_start_duration (hot_start_duration),
		.run_duration       (run_duration),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.was_hot            (was_hot),
		.start_latency      (start_latency),
		.build_charged      (build_charged),
		.run_charged        (run_charged),
		.table_full         (table_full),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d charges outstanding", cycles,
				pending_charges.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// shadow table
	// ---------------------------------------------------------------------

	// lowest occupied slot holding this id, or -1
	function automatic int find_slot(bit [ID_W-1:0] fid);
		for (int i = 0; i < tbl_used; i++)
			if (tbl_valid[i] && tbl_fid[i] == fid)
				return i;
		return -1;
	endfunction

	// charges for one job, and the window update it causes
	function automatic charge_t serve_request(job_t j);
		longint unsigned open_sum;
		longint unsigned close_sum;
		bit [TIME_W-1:0] open_c;
		bit [TIME_W-1:0] close_c;
		int              slot;
		charge_t         c;
		// both window candidates saturate at the top of the tick range
		open_sum  = 64'(j.sub) + 64'(j.bld);
		close_sum = open_sum + 64'(j.cold) + 64'(j.run) + 64'(keep_alive);
		open_c    = (open_sum > 64'hFFFF_FFFF) ? '1 : open_sum[TIME_W-1:0];
		close_c   = (close_sum > 64'hFFFF_FFFF) ? '1 : close_sum[TIME_W-1:0];
		slot      = find_slot(j.fid);
		c         = '0;
		c.run     = j.run;
		if (slot >= 0) begin
			// hot only inside the window, both ends included
			c.hot = (tbl_open[slot] <= j.sub) && (tbl_close[slot] >= j.sub);
			if (open_c < tbl_open[slot])
				tbl_open[slot] = open_c;
			if (close_c > tbl_close[slot])
				tbl_close[slot] = close_c;
		end else if (tbl_used < ENTRIES) begin
			tbl_valid[tbl_used] = 1'b1;
			tbl_fid[tbl_used]   = j.fid;
			tbl_open[tbl_used]  = open_c;
			tbl_close[tbl_used] = close_c;
			tbl_used++;
		end else begin
			// unknown id with no room left: served cold, nothing stored
			c.full = 1'b1;
		end
		c.latency = c.hot ? j.hot : j.cold;
		c.build   = c.hot ? '0 : j.bld;
		return c;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	function automatic job_t make_job(bit [ID_W-1:0] fid, bit [TIME_W-1:0] sub,
		bit [DUR_W-1:0] bld, bit [DUR_W-1:0] cold, bit [DUR_W-1:0] hot,
		bit [DUR_W-1:0] run);
		job_t j;
		j.fid  = fid;
		j.sub  = sub;
		j.bld  = bld;
		j.cold = cold;
		j.hot  = hot;
		j.run  = run;
		return j;
	endfunction

	// mostly short durations so windows stay narrow, with the extremes mixed in
	function automatic bit [DUR_W-1:0] rand_duration();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return DUR_W'($urandom);
			default: return DUR_W'($urandom_range(0, 4000));
		endcase
	endfunction

	function automatic bit [ID_W-1:0] fresh_fid();
		bit [ID_W-1:0] f;
		do
			f = ID_W'($urandom);
		while (find_slot(f) >= 0);
		return f;
	endfunction

	// submit tick for a known id: window edges, just outside, inside, nearby, anywhere
	function automatic bit [TIME_W-1:0] probe_time(int slot);
		bit [TIME_W-1:0] lo;
		bit [TIME_W-1:0] hi;
		longint unsigned span;
		lo = tbl_open[slot];
		hi = tbl_close[slot];
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			2: return lo - 1;
			3: return hi + 1;
			4, 5, 6: begin
				span = 64'(hi) - 64'(lo) + 1;
				return lo + TIME_W'(64'($urandom) % span);
			end
			7: return lo - $urandom_range(0, 50000);
			8: return hi + $urandom_range(0, 50000);
			default: return $urandom;
		endcase
	endfunction

	// a resubmission of a stored id, or a first submission of an unknown one
	function automatic job_t random_job(int fresh_pct);
		job_t j;
		int   slot;
		j.bld  = rand_duration();
		j.cold = rand_duration();
		j.hot  = rand_duration();
		j.run  = rand_duration();
		if (tbl_used == 0 || $urandom_range(0, 99) < fresh_pct) begin
			j.fid = fresh_fid();
			// now and then close to the top of the tick range, to hit saturation
			j.sub = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 60000)
				: TIME_W'($urandom);
		end else begin
			slot  = $urandom_range(0, tbl_used - 1);
			j.fid = tbl_fid[slot];
			j.sub = probe_time(slot);
		end
		return j;
	endfunction

	// ---------------------------------------------------------------------
	// request channel driver
	// ---------------------------------------------------------------------

	// offers one job, holds it until the beat is taken, then books its charges
	task automatic send_job(job_t j);
		int gap;
		gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid            <= 1'b1;
		function_id         <= j.fid;
		submit_time         <= j.sub;
		build_duration      <= j.bld;
		cold_start_duration <= j.cold;
		hot_start_duration  <= j.hot;
		run_duration        <= j.run;
		do
			@(posedge clk);
		while (in_stall);
		pending_charges.push_back(serve_request(j));
	endtask

	// stop offering, wait for every owed charge, then let the row empty out
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_charges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// keep-alive register is only touched with the block idle
	task automatic write_keep_alive(bit [DUR_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		keep_alive = value;
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// result channel: stall generator and checker
	// ---------------------------------------------------------------------

	// random stall bursts, plus one long hold-off on request from the test sequence
	always @(posedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken = holds_asked;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			burst_left = $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic report_mismatch(string what, charge_t want, charge_t got);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected hot=%0d latency=%h build=%h run=%h full=%0d",
				want.hot, want.latency, want.build, want.run, want.full);
			$display("  actual   hot=%0d latency=%h build=%h run=%h full=%0d",
				got.hot, got.latency, got.build, got.run, got.full);
		end
	endtask

	// every result beat is matched against the oldest owed charge
	always @(posedge clk) begin : check_beat
		charge_t got;
		charge_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got.hot     = was_hot;
			got.latency = start_latency;
			got.build   = build_charged;
			got.run     = run_charged;
			got.full    = table_full;
			if (pending_charges.size() == 0) begin
				report_mismatch("result beat with nothing owed", 'x, got);
			end else begin
				want = pending_charges.pop_front();
				if (got.hot !== want.hot || got.latency !== want.latency
					|| got.build !== want.build || got.run !== want.run
					|| got.full !== want.full)
					report_mismatch("charge mismatch", want, got);
			end
		end
	end

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// all-zero and all-one fields, alternating bit patterns, saturating sums
	task automatic test_field_extremes();
		write_keep_alive('0);
		// new id with a window holding only tick zero, then a hot hit on it
		send_job(make_job('0, '0, '0, '0, '0, '0));
		send_job(make_job('0, '0, '1, '0, '1, '1));
		// top of every range: both window sums saturate
		send_job(make_job('1, '1, '1, '1, '0, '1));
		send_job(make_job('1, '1, '1, '1, '1, '1));
		send_job(make_job('1, 32'hFFFF_FFFE, '0, '1, '1, '0));
		send_job(make_job(16'hAAAA, 32'hAAAA_AAAA, 24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA,
			24'hAAAAAA));
		send_job(make_job(16'h5555, 32'h5555_5555, 24'h555555, 24'h555555, 24'h555555,
			24'h555555));
		// window of id zero was widened by the earlier long durations
		send_job(make_job('0, 32'd1, 24'd7, 24'd9, 24'd11, 24'd13));
	endtask

	// submits right on and just past each edge of one window
	task automatic test_window_edges();
		bit [TIME_W-1:0] t;
		int              slot;
		write_keep_alive(24'h000100);
		send_job(make_job(16'hA5A5, 32'h0001_0000, 24'd100, 24'd20, 24'd5, 24'd30));
		slot = find_slot(16'hA5A5);
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: t = tbl_open[slot];
				1: t = tbl_close[slot];
				2: t = tbl_open[slot] - 1;
				default: t = tbl_close[slot] + 1;
			endcase
			send_job(make_job(16'hA5A5, t, 24'd3, 24'd20, 24'd5, 24'd30));
		end
		// zero build time moves the open edge down to the submit tick itself
		t = tbl_open[slot] - 2;
		send_job(make_job(16'hA5A5, t, '0, '0, 24'd5, '0));
		send_job(make_job(16'hA5A5, t, '0, '0, 24'd5, '0));
	endtask

	// long hold-off on the result side while requests keep coming
	task automatic test_backpressure();
		no_idle = 1'b1;
		holds_asked++;
		repeat (6) send_job(random_job(40));
		no_idle = 1'b0;
	endtask

	// fill every slot, then offer ids that no longer fit
	task automatic test_table_full();
		job_t j;
		while (tbl_used < ENTRIES)
			send_job(random_job(100));
		repeat (3) send_job(random_job(100));
		// an id refused once is refused again
		j = random_job(100);
		send_job(j);
		send_job(j);
		send_job(make_job(fresh_fid(), '1, '1, '1, '1, '1));
		// stored ids are still served
		send_job(random_job(0));
		send_job(random_job(0));
	endtask

	// mix of resubmissions and new ids; the tail runs without idling
	task automatic test_random_traffic(bit [DUR_W-1:0] window, int count, int fresh_pct,
		int quiet_tail);
		write_keep_alive(window);
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count - quiet_tail);
			send_job(random_job(fresh_pct));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_window_edges();
		test_backpressure();
		test_random_traffic('1, 340, 30, 0);
		test_table_full();
		test_random_traffic(DUR_W'($urandom_range(1, 24'hFFFFFE)), 340, 30, 0);
		test_random_traffic('0, 320, 20, 120);

		settle();
		if (pending_charges.size() != 0)
			errors += pending_charges.size();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/wswt_pkg.sv
src/wswt_cell.sv
src/warm_start_window_table_core.sv
bench/tb_top.sv
